// File: src/htsc_pkg.sv
// ----------------------------------------------------------------------------
// htsc_pkg: shared types and constants for the hex token syntax checker
// Scan modes, verdict codes, character codes and the per-item result.
// ----------------------------------------------------------------------------
package htsc_pkg;

  localparam int unsigned DEPTH_BITS_DEF = 16;
  localparam int unsigned LINE_BITS_DEF  = 24;

  typedef enum logic [1:0] {
    MODE_TOP,
    MODE_IDENT,
    MODE_HEX_X,
    MODE_HEX_DIG
  } scan_mode_t;

  typedef enum logic [2:0] {
    V_PENDING,
    V_ACCEPT,
    V_BADCHAR,
    V_BADIDENT,
    V_NOX,
    V_BADHEX,
    V_BRACKET
  } verdict_t;

  typedef logic [7:0]  byte_t;
  typedef logic [23:0] line_out_t;

  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_X      = 8'h78;
  localparam byte_t CH_LPAR   = 8'h28;
  localparam byte_t CH_RPAR   = 8'h29;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_BANG   = 8'h21;
  localparam byte_t CH_TILDE  = 8'h7E;
  localparam byte_t CH_NL     = 8'h0A;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_SPACE  = 8'h20;

  typedef struct packed {
    verdict_t  verdict;
    line_out_t line_number;
    byte_t     bad_byte;
    logic      final_res;
  } result_t;

  function automatic logic is_space(input byte_t c);
    is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_hex(input byte_t c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

endpackage

// File: src/htsc_scan.sv
// ----------------------------------------------------------------------------
// htsc_scan: scanner state and single-item step
// Holds mode, bracket depth, line count and the latched error; works out
// the result for one item and the next state combinationally.
// ----------------------------------------------------------------------------
module htsc_scan #(
  parameter int unsigned DEPTH_BITS = htsc_pkg::DEPTH_BITS_DEF,
  parameter int unsigned LINE_BITS  = htsc_pkg::LINE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  htsc_pkg::byte_t   text_byte,
  input  logic              end_marker,
  output htsc_pkg::result_t res
);

  htsc_pkg::scan_mode_t mode, mode_next;
  logic [DEPTH_BITS-1:0] depth, depth_next;
  logic [LINE_BITS-1:0]  line_cnt, line_cnt_next;
  htsc_pkg::verdict_t    err_code, err_code_next;
  htsc_pkg::byte_t       err_byte, err_byte_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= htsc_pkg::MODE_TOP;
      depth    <= '0;
      line_cnt <= LINE_BITS'(1);
      err_code <= htsc_pkg::V_PENDING;
      err_byte <= '0;
    end else if (step) begin
      mode     <= mode_next;
      depth    <= depth_next;
      line_cnt <= line_cnt_next;
      err_code <= err_code_next;
      err_byte <= err_byte_next;
    end
  end

  always_comb begin
    logic handback;
    logic sep;
    logic do_top;
    handback = (text_byte == htsc_pkg::CH_DOT) || (text_byte == htsc_pkg::CH_LPAR) ||
               (text_byte == htsc_pkg::CH_RPAR) || (text_byte == htsc_pkg::CH_NL);
    sep = (text_byte == htsc_pkg::CH_COMMA) || (text_byte == htsc_pkg::CH_SEMI) ||
          htsc_pkg::is_space(text_byte);
    do_top = 1'b0;

    mode_next     = mode;
    depth_next    = depth;
    line_cnt_next = line_cnt;
    err_code_next = err_code;
    err_byte_next = err_byte;

    if (end_marker) begin
      if (err_code == htsc_pkg::V_PENDING) begin
        if (mode == htsc_pkg::MODE_HEX_X) begin
          err_code_next = htsc_pkg::V_NOX;
          err_byte_next = '0;
        end else if (depth != '0) begin
          err_code_next = htsc_pkg::V_BRACKET;
          err_byte_next = '0;
        end
      end
    end else if (err_code == htsc_pkg::V_PENDING) begin
      case (mode)
        htsc_pkg::MODE_IDENT, htsc_pkg::MODE_HEX_DIG: begin
          if (handback) begin
            mode_next = htsc_pkg::MODE_TOP;
            do_top    = 1'b1;
          end else if (sep) begin
            mode_next = htsc_pkg::MODE_TOP;
          end else if (mode == htsc_pkg::MODE_IDENT) begin
            if (text_byte < htsc_pkg::CH_BANG || text_byte > htsc_pkg::CH_TILDE) begin
              err_code_next = htsc_pkg::V_BADIDENT;
              err_byte_next = text_byte;
            end
          end else if (!htsc_pkg::is_hex(text_byte)) begin
            err_code_next = htsc_pkg::V_BADHEX;
            err_byte_next = text_byte;
          end
        end
        htsc_pkg::MODE_HEX_X: begin
          if (text_byte == htsc_pkg::CH_X) begin
            mode_next = htsc_pkg::MODE_HEX_DIG;
          end else begin
            err_code_next = htsc_pkg::V_NOX;
            err_byte_next = text_byte;
          end
        end
        default: begin
          mode_next = htsc_pkg::MODE_TOP;
          do_top    = 1'b1;
        end
      endcase

      if (do_top) begin
        if (text_byte == htsc_pkg::CH_DOT) begin
          mode_next = htsc_pkg::MODE_IDENT;
        end else if (text_byte == htsc_pkg::CH_ZERO) begin
          mode_next = htsc_pkg::MODE_HEX_X;
        end else if (text_byte == htsc_pkg::CH_LPAR) begin
          if (&depth) begin
            err_code_next = htsc_pkg::V_BRACKET;
            err_byte_next = '0;
          end else begin
            depth_next = depth + DEPTH_BITS'(1);
          end
        end else if (text_byte == htsc_pkg::CH_RPAR) begin
          if (depth == '0) begin
            err_code_next = htsc_pkg::V_BRACKET;
            err_byte_next = '0;
          end else begin
            depth_next = depth - DEPTH_BITS'(1);
          end
        end else if (text_byte == htsc_pkg::CH_NL) begin
          if (!(&line_cnt)) line_cnt_next = line_cnt + LINE_BITS'(1);
        end else if (!sep) begin
          err_code_next = htsc_pkg::V_BADCHAR;
          err_byte_next = text_byte;
        end
      end
    end

    // result reflects state after this item, before any rearm
    if (end_marker && err_code_next == htsc_pkg::V_PENDING) begin
      res.verdict = htsc_pkg::V_ACCEPT;
    end else begin
      res.verdict = err_code_next;
    end
    res.line_number = htsc_pkg::line_out_t'(line_cnt_next);
    res.bad_byte    = (err_code_next != htsc_pkg::V_PENDING) ? err_byte_next : '0;
    res.final_res   = end_marker;

    if (end_marker) begin
      mode_next     = htsc_pkg::MODE_TOP;
      depth_next    = '0;
      line_cnt_next = LINE_BITS'(1);
      err_code_next = htsc_pkg::V_PENDING;
      err_byte_next = '0;
    end
  end

endmodule

// File: src/hex_token_syntax_checker.sv
// ----------------------------------------------------------------------------
// hex_token_syntax_checker: top level
// Input register, scanner step and result register for the token checker.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser
// s_axis    in   [7:0] text_byte                         [0] end_marker
// m_axis    out  [2:0] verdict, [26:3] line_number,      [0] final_res
//                [34:27] bad_byte, [39:35] zero
//
// One item per cycle unless the result stalls; an item passes the input
// register, then the result register. Scanner state updates in the cycle an
// item moves from the input to the result register. A stalled result holds
// both stages; the input side keeps accepting while the input register can
// drain. Reset is synchronous and clears all control and scanner state.
// ----------------------------------------------------------------------------
module hex_token_syntax_checker #(
  parameter int unsigned DEPTH_BITS = htsc_pkg::DEPTH_BITS_DEF,
  parameter int unsigned LINE_BITS  = htsc_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] end_marker
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // verdict, line_number, bad_byte, pad
  output logic        m_axis_tuser    // [0] final_res
);

  logic              in_valid;
  htsc_pkg::byte_t   in_byte;
  logic              in_end;
  logic              advance;
  logic              step;
  htsc_pkg::result_t res;
  htsc_pkg::result_t out_res;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tuser;
    end
  end

  htsc_scan #(
    .DEPTH_BITS (DEPTH_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .text_byte  (in_byte),
    .end_marker (in_end),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {5'b0, out_res.bad_byte, out_res.line_number, out_res.verdict};
  assign m_axis_tuser = out_res.final_res;

endmodule
